// ===== rtl/core/quadratic_root_solver_assert.svh =====
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion forms for the solver RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define QRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, root kind codes and per-stage item records for the root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // discriminant magnitude: |b*b - 4*a*c|
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int D_W       = PROD_W + 2;
  // square root, one result bit per cell
  localparam int SQ_W      = D_W / 2;
  localparam int REM_W     = SQ_W + 2;
  // numerator magnitude |-b +/- s| and its scaled form
  localparam int NUM_W     = SQ_W + 1;
  localparam int NS_W      = NUM_W + FRAC_BITS;
  // divisor 2|a|
  localparam int DEN_W     = WORD_BITS + 1;

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_A_ZERO   = 2'd3
  } kind_t;

  // coefficient facts that travel with an item
  typedef struct packed {
    logic                 a_neg;
    logic [WORD_BITS-1:0] a_mag;
    logic                 b_neg;
    logic [WORD_BITS-1:0] b_mag;
    logic                 d_neg;
    logic                 d_zero;
    logic                 a_zero;
  } ctx_t;

  // square root cell record
  typedef struct packed {
    ctx_t             ctx;
    logic [D_W-1:0]   rad;
    logic [REM_W-1:0] rem;
    logic [SQ_W-1:0]  root;
  } sq_t;

  // divider cell record, two lanes share the divisor
  typedef struct packed {
    ctx_t             ctx;
    logic             neg1;
    logic             neg2;
    logic [NS_W-1:0]  num1;
    logic [NS_W-1:0]  num2;
    logic [DEN_W-1:0] rem1;
    logic [DEN_W-1:0] rem2;
    logic [NS_W-1:0]  q1;
    logic [NS_W-1:0]  q2;
  } dv_t;

endpackage

// ===== rtl/core/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit step of the restoring square root: two radicand bits in,
// one root bit out, registered toward the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  qrs_pkg::sq_t  in_sq,
  output logic          out_valid,
  output qrs_pkg::sq_t  out_sq
);

  logic               valid_r;
  qrs_pkg::sq_t       sq_r;
  qrs_pkg::sq_t       sq_nxt;
  logic [qrs_pkg::REM_W-1:0] rem_sh;
  logic [qrs_pkg::REM_W-1:0] trial;

  // trial subtract of 4*root+1
  always_comb begin
    rem_sh = {in_sq.rem[qrs_pkg::REM_W-3:0], in_sq.rad[qrs_pkg::D_W-1 -: 2]};
    trial  = {in_sq.root, 2'b01};
    sq_nxt = in_sq;
    sq_nxt.rad = {in_sq.rad[qrs_pkg::D_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_nxt.rem  = rem_sh - trial;
      sq_nxt.root = {in_sq.root[qrs_pkg::SQ_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem_sh;
      sq_nxt.root = {in_sq.root[qrs_pkg::SQ_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_sq    = sq_r;

endmodule

// ===== rtl/core/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of two restoring long divisions by 2|a|,
// registered toward the next cell.
// ----------------------------------------------------------------------------
module qrs_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  qrs_pkg::dv_t  in_dv,
  output logic          out_valid,
  output qrs_pkg::dv_t  out_dv
);

  logic                      valid_r;
  qrs_pkg::dv_t              dv_r;
  qrs_pkg::dv_t              dv_nxt;
  logic [qrs_pkg::DEN_W:0]   den;
  logic [qrs_pkg::DEN_W:0]   sh1;
  logic [qrs_pkg::DEN_W:0]   sh2;
  logic [qrs_pkg::DEN_W:0]   df1;
  logic [qrs_pkg::DEN_W:0]   df2;

  // shift in next numerator bit, subtract when it fits
  always_comb begin
    den = {1'b0, in_dv.ctx.a_mag, 1'b0};
    sh1 = {in_dv.rem1, in_dv.num1[qrs_pkg::NS_W-1]};
    sh2 = {in_dv.rem2, in_dv.num2[qrs_pkg::NS_W-1]};
    df1 = sh1 - den;
    df2 = sh2 - den;
    dv_nxt = in_dv;
    dv_nxt.num1 = {in_dv.num1[qrs_pkg::NS_W-2:0], 1'b0};
    dv_nxt.num2 = {in_dv.num2[qrs_pkg::NS_W-2:0], 1'b0};
    if (sh1 >= den) begin
      dv_nxt.rem1 = df1[qrs_pkg::DEN_W-1:0];
      dv_nxt.q1   = {in_dv.q1[qrs_pkg::NS_W-2:0], 1'b1};
    end else begin
      dv_nxt.rem1 = sh1[qrs_pkg::DEN_W-1:0];
      dv_nxt.q1   = {in_dv.q1[qrs_pkg::NS_W-2:0], 1'b0};
    end
    if (sh2 >= den) begin
      dv_nxt.rem2 = df2[qrs_pkg::DEN_W-1:0];
      dv_nxt.q2   = {in_dv.q2[qrs_pkg::NS_W-2:0], 1'b1};
    end else begin
      dv_nxt.rem2 = sh2[qrs_pkg::DEN_W-1:0];
      dv_nxt.q2   = {in_dv.q2[qrs_pkg::NS_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r <= dv_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_dv    = dv_r;

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c in signed Q16.16 with exact discriminant,
// cell-chain square root and cell-chain dividers.
// ----------------------------------------------------------------------------
// Takes one coefficient item per cycle while the output is not stalled and
// returns one result item per item, in order. The pipeline holds the operand
// split, multiply and discriminant registers, one square root cell per root
// bit, one numerator stage, one divider cell per quotient bit and the output
// register. The whole row of cells moves together and halts only while the
// output register holds an item that is not taken.
module quadratic_root_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_a,
  input  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_b,
  input  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_root_kind,
  output logic signed [qrs_pkg::WORD_BITS-1:0] out_first_value,
  output logic signed [qrs_pkg::WORD_BITS-1:0] out_second_value,
  output logic                          out_saturated
);

  `include "quadratic_root_solver_assert.svh"

  localparam int WB = qrs_pkg::WORD_BITS;
  localparam int NW = qrs_pkg::NS_W;
  localparam logic [NW-1:0] LIM_NEG = NW'(1) << (WB - 1);
  localparam logic [NW-1:0] LIM_POS = LIM_NEG - NW'(1);

  logic en;

  // stage 1: sign and magnitude
  logic                v1_r;
  qrs_pkg::ctx_t       ctx1_r;
  logic                c_neg_r;
  logic [WB-1:0]       c_mag_r;

  // stage 2: products
  logic                v2_r;
  qrs_pkg::ctx_t       ctx2_r;
  logic                sub_r;
  logic [qrs_pkg::PROD_W-1:0] bb_r;
  logic [qrs_pkg::PROD_W-1:0] ac_r;

  // stage 3 and numerator stage registers
  logic                sq0_v_r;
  qrs_pkg::sq_t        sq0_r;
  logic                dv0_v_r;
  qrs_pkg::dv_t        dv0_r;

  // chains
  logic                sq_v   [qrs_pkg::SQ_W+1];
  qrs_pkg::sq_t        sq_p   [qrs_pkg::SQ_W+1];
  logic                dv_v   [NW+1];
  qrs_pkg::dv_t        dv_p   [NW+1];

  logic [qrs_pkg::D_W-1:0] bbx;
  logic [qrs_pkg::D_W-1:0] ac4;
  qrs_pkg::sq_t        sq_nxt;

  logic signed [qrs_pkg::NUM_W+1:0] nb;
  logic signed [qrs_pkg::NUM_W+1:0] sx;
  logic signed [qrs_pkg::NUM_W+1:0] t1;
  logic signed [qrs_pkg::NUM_W+1:0] t2;
  logic signed [qrs_pkg::NUM_W+1:0] tb;
  logic [qrs_pkg::NUM_W+1:0] m1;
  logic [qrs_pkg::NUM_W+1:0] m2;
  logic [qrs_pkg::NUM_W+1:0] mb;
  qrs_pkg::dv_t        dv_nxt;

  logic [WB:0]         f1;
  logic [WB:0]         f2;
  qrs_pkg::dv_t        dv_end;
  logic [1:0]          kind_nxt;

  logic                out_valid_r;
  logic [1:0]          kind_r;
  logic [WB-1:0]       first_r;
  logic [WB-1:0]       second_r;
  logic                sat_r;

  // saturate a quotient and apply its sign: {clipped, value}
  function automatic logic [WB:0] finish(input logic [NW-1:0] q, input logic qneg);
    logic [NW-1:0] lim;
    logic [NW-1:0] qq;
    logic          clip;
    lim  = qneg ? LIM_NEG : LIM_POS;
    clip = q > lim;
    qq   = clip ? lim : q;
    qq   = qneg ? (NW'(0) - qq) : qq;
    return {clip, qq[WB-1:0]};
  endfunction

  // whole chain advances unless the output holds an untaken item
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r.a_neg  <= in_coef_a[WB-1];
      ctx1_r.a_mag  <= in_coef_a[WB-1] ? WB'(-in_coef_a) : WB'(in_coef_a);
      ctx1_r.b_neg  <= in_coef_b[WB-1];
      ctx1_r.b_mag  <= in_coef_b[WB-1] ? WB'(-in_coef_b) : WB'(in_coef_b);
      ctx1_r.d_neg  <= 1'b0;
      ctx1_r.d_zero <= 1'b0;
      ctx1_r.a_zero <= in_coef_a == '0;
      c_neg_r       <= in_coef_c[WB-1];
      c_mag_r       <= in_coef_c[WB-1] ? WB'(-in_coef_c) : WB'(in_coef_c);
    end
  end

  // stage 2: b*b and a*c
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r <= ctx1_r;
      sub_r  <= (ctx1_r.a_neg == c_neg_r) && (c_mag_r != '0);
      bb_r   <= qrs_pkg::PROD_W'(ctx1_r.b_mag) * qrs_pkg::PROD_W'(ctx1_r.b_mag);
      ac_r   <= qrs_pkg::PROD_W'(ctx1_r.a_mag) * qrs_pkg::PROD_W'(c_mag_r);
    end
  end

  // stage 3: discriminant as sign and magnitude
  always_comb begin
    bbx    = {2'b00, bb_r};
    ac4    = {ac_r, 2'b00};
    sq_nxt = '0;
    sq_nxt.ctx = ctx2_r;
    if (sub_r && (bbx < ac4)) begin
      sq_nxt.rad       = ac4 - bbx;
      sq_nxt.ctx.d_neg = 1'b1;
    end else if (sub_r) begin
      sq_nxt.rad = bbx - ac4;
    end else begin
      sq_nxt.rad = bbx + ac4;
    end
    sq_nxt.ctx.d_zero = sq_nxt.rad == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq0_v_r <= 1'b0;
    end else if (en) begin
      sq0_v_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r <= sq_nxt;
    end
  end

  assign sq_v[0] = sq0_v_r;
  assign sq_p[0] = sq0_r;

  // square root cell row
  for (genvar k = 0; k < qrs_pkg::SQ_W; k++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[k]),
      .in_sq     (sq_p[k]),
      .out_valid (sq_v[k+1]),
      .out_sq    (sq_p[k+1])
    );
  end

  // numerators -b+s, -b-s, -b or s per root kind
  always_comb begin
    nb = (qrs_pkg::NUM_W+2)'(sq_p[qrs_pkg::SQ_W].ctx.b_mag);
    nb = sq_p[qrs_pkg::SQ_W].ctx.b_neg ? nb : -nb;
    sx = $signed({3'b000, sq_p[qrs_pkg::SQ_W].root});
    t1 = nb + sx;
    t2 = nb - sx;
    tb = nb;
    m1 = t1[qrs_pkg::NUM_W+1] ? -t1 : t1;
    m2 = t2[qrs_pkg::NUM_W+1] ? -t2 : t2;
    mb = tb[qrs_pkg::NUM_W+1] ? -tb : tb;
    dv_nxt = '0;
    dv_nxt.ctx = sq_p[qrs_pkg::SQ_W].ctx;
    if (sq_p[qrs_pkg::SQ_W].ctx.d_zero) begin
      dv_nxt.neg1 = tb[qrs_pkg::NUM_W+1];
      dv_nxt.num1 = {mb[qrs_pkg::NUM_W-1:0], qrs_pkg::FRAC_BITS'(0)};
    end else if (sq_p[qrs_pkg::SQ_W].ctx.d_neg) begin
      dv_nxt.neg1 = tb[qrs_pkg::NUM_W+1];
      dv_nxt.num1 = {mb[qrs_pkg::NUM_W-1:0], qrs_pkg::FRAC_BITS'(0)};
      dv_nxt.num2 = {1'b0, sq_p[qrs_pkg::SQ_W].root, qrs_pkg::FRAC_BITS'(0)};
    end else begin
      dv_nxt.neg1 = t1[qrs_pkg::NUM_W+1];
      dv_nxt.num1 = {m1[qrs_pkg::NUM_W-1:0], qrs_pkg::FRAC_BITS'(0)};
      dv_nxt.neg2 = t2[qrs_pkg::NUM_W+1];
      dv_nxt.num2 = {m2[qrs_pkg::NUM_W-1:0], qrs_pkg::FRAC_BITS'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv0_v_r <= 1'b0;
    end else if (en) begin
      dv0_v_r <= sq_v[qrs_pkg::SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv0_r <= dv_nxt;
    end
  end

  assign dv_v[0] = dv0_v_r;
  assign dv_p[0] = dv0_r;

  // divider cell row
  for (genvar k = 0; k < NW; k++) begin : g_dv
    qrs_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[k]),
      .in_dv     (dv_p[k]),
      .out_valid (dv_v[k+1]),
      .out_dv    (dv_p[k+1])
    );
  end

  // saturation, sign and root kind
  always_comb begin
    dv_end = dv_p[NW];
    f1 = finish(dv_end.q1, dv_end.neg1 ^ dv_end.ctx.a_neg);
    f2 = finish(dv_end.q2, dv_end.neg2 ^ dv_end.ctx.a_neg);
    if (dv_end.ctx.a_zero) begin
      kind_nxt = qrs_pkg::KIND_A_ZERO;
    end else if (dv_end.ctx.d_zero) begin
      kind_nxt = qrs_pkg::KIND_DOUBLE;
    end else if (dv_end.ctx.d_neg) begin
      kind_nxt = qrs_pkg::KIND_COMPLEX;
    end else begin
      kind_nxt = qrs_pkg::KIND_TWO_REAL;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= kind_nxt;
      if (dv_end.ctx.a_zero) begin
        first_r  <= '0;
        second_r <= '0;
        sat_r    <= 1'b0;
      end else begin
        first_r  <= f1[WB-1:0];
        second_r <= f2[WB-1:0];
        sat_r    <= f1[WB] | f2[WB];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_root_kind    = kind_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_saturated    = sat_r;

  // checks
  `QRS_ASSERT_IMPLY(a_sqrt_rem_bound, clk, rst_n, sq_v[qrs_pkg::SQ_W],
    sq_p[qrs_pkg::SQ_W].rem <= {1'b0, sq_p[qrs_pkg::SQ_W].root, 1'b0})
  `QRS_ASSERT_IMPLY(a_zero_result, clk, rst_n,
    out_valid_r && (kind_r == qrs_pkg::KIND_A_ZERO),
    (first_r == '0) && (second_r == '0) && !sat_r)
  `QRS_ASSERT_IMPLY(a_double_second, clk, rst_n,
    out_valid_r && (kind_r == qrs_pkg::KIND_DOUBLE), second_r == '0)
  `QRS_ASSERT_NEXT(a_stall_holds_chain, clk, rst_n,
    out_valid_r && !out_ready, dv_v[NW] == $past(dv_v[NW]))

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives coefficient items into quadratic_root_solver with random idling on
// both handshakes and a long receiver hold-off, predicts each root item with
// an independent wide-integer solver and checks results field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_RANDOM    = 930;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 120;

  typedef struct {
    logic [qrs_pkg::WORD_BITS-1:0] a;
    logic [qrs_pkg::WORD_BITS-1:0] b;
    logic [qrs_pkg::WORD_BITS-1:0] c;
  } coef_t;

  typedef struct {
    qrs_pkg::kind_t                kind;
    logic [qrs_pkg::WORD_BITS-1:0] first;
    logic [qrs_pkg::WORD_BITS-1:0] second;
    logic                          sat;
  } roots_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_a = '0;
  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_b = '0;
  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_root_kind;
  logic signed [qrs_pkg::WORD_BITS-1:0] out_first_value;
  logic signed [qrs_pkg::WORD_BITS-1:0] out_second_value;
  logic out_saturated;

  coef_t  coef_queue[$];
  roots_t roots_queue[$];
  int     errors = 0;
  int     n_total = 0;
  int     n_sent = 0;
  int     n_taken = 0;
  int     cycles = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  logic   in_taken = 1'b0;

  quadratic_root_solver dut (.*);

  always #1 clk = ~clk;

  // truncating divide of a signed numerator by 2a, clipped to the word range
  function automatic logic [qrs_pkg::WORD_BITS-1:0] div_2a(input logic n_neg,
                                                           input logic [127:0] n_mag,
                                                           input logic a_neg,
                                                           input logic [63:0] a_mag,
                                                           inout logic sat);
    logic [127:0] quo;
    logic [127:0] lim;
    logic         q_neg;
    q_neg = n_neg ^ a_neg;
    quo   = (n_mag << qrs_pkg::FRAC_BITS) / {a_mag, 1'b0};
    lim   = q_neg ? (128'd1 << (qrs_pkg::WORD_BITS - 1))
                  : (128'd1 << (qrs_pkg::WORD_BITS - 1)) - 1;
    if (quo > lim) begin
      quo = lim;
      sat = 1'b1;
    end
    if (q_neg) quo = -quo;
    return quo[qrs_pkg::WORD_BITS-1:0];
  endfunction

  // roots of one coefficient item
  function automatic roots_t solve_roots(input coef_t cf);
    roots_t       r;
    logic         a_neg, b_neg, c_neg, d_neg;
    logic [63:0]  a_mag, b_mag, c_mag, sq, cand;
    logic [127:0] bb, ac4, d_mag, num_mag;
    logic signed [127:0] num;
    a_neg = cf.a[qrs_pkg::WORD_BITS-1];
    b_neg = cf.b[qrs_pkg::WORD_BITS-1];
    c_neg = cf.c[qrs_pkg::WORD_BITS-1];
    a_mag = a_neg ? 64'(-cf.a) & ((64'd1 << qrs_pkg::WORD_BITS) - 1) : 64'(cf.a);
    b_mag = b_neg ? 64'(-cf.b) & ((64'd1 << qrs_pkg::WORD_BITS) - 1) : 64'(cf.b);
    c_mag = c_neg ? 64'(-cf.c) & ((64'd1 << qrs_pkg::WORD_BITS) - 1) : 64'(cf.c);
    r.sat = 1'b0;
    r.first = '0;
    r.second = '0;
    if (a_mag == 0) begin
      r.kind = qrs_pkg::KIND_A_ZERO;
      return r;
    end
    bb  = 128'(b_mag) * 128'(b_mag);
    ac4 = (128'(a_mag) * 128'(c_mag)) << 2;
    d_neg = 1'b0;
    if (a_neg == c_neg && c_mag != 0) begin
      if (bb >= ac4) d_mag = bb - ac4;
      else begin
        d_neg = 1'b1;
        d_mag = ac4 - bb;
      end
    end else d_mag = bb + ac4;
    // floor square root, one bit at a time
    sq = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = sq | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= d_mag) sq = cand;
    end
    if (d_mag == 0) begin
      r.kind  = qrs_pkg::KIND_DOUBLE;
      r.first = div_2a(!b_neg, 128'(b_mag), a_neg, a_mag, r.sat);
    end else if (!d_neg) begin
      r.kind = qrs_pkg::KIND_TWO_REAL;
      num = (b_neg ? $signed(128'(b_mag)) : -$signed(128'(b_mag))) + $signed(128'(sq));
      num_mag = num < 0 ? -num : num;
      r.first = div_2a(num < 0, num_mag, a_neg, a_mag, r.sat);
      num = (b_neg ? $signed(128'(b_mag)) : -$signed(128'(b_mag))) - $signed(128'(sq));
      num_mag = num < 0 ? -num : num;
      r.second = div_2a(num < 0, num_mag, a_neg, a_mag, r.sat);
    end else begin
      r.kind   = qrs_pkg::KIND_COMPLEX;
      r.first  = div_2a(!b_neg, 128'(b_mag), a_neg, a_mag, r.sat);
      r.second = div_2a(1'b0, 128'(sq), a_neg, a_mag, r.sat);
    end
    return r;
  endfunction

  function automatic logic [qrs_pkg::WORD_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0: return {1'b1, {(qrs_pkg::WORD_BITS-1){1'b0}}};
      1: return {1'b0, {(qrs_pkg::WORD_BITS-1){1'b1}}};
      2: return '1;
      3: return '0;
      4: return 1;
      5: return 32'sd1 <<< qrs_pkg::FRAC_BITS;
      default: return -(32'sd1 <<< qrs_pkg::FRAC_BITS);
    endcase
  endfunction

  // value of moderate size, scaled by a random shift
  function automatic logic [qrs_pkg::WORD_BITS-1:0] pick_scaled();
    logic signed [qrs_pkg::WORD_BITS-1:0] v;
    v = $signed($urandom) >>> $urandom_range(0, 31);
    return v;
  endfunction

  task automatic push_coef(input logic [qrs_pkg::WORD_BITS-1:0] a, b, c);
    coef_t cf;
    cf.a = a;
    cf.b = b;
    cf.c = c;
    coef_queue.push_back(cf);
    n_total++;
  endtask

  // stimulus and end of run
  initial begin
    logic [qrs_pkg::WORD_BITS-1:0] p, q;
    // directed: zero a, double, complex, two real, extremes, saturation
    push_coef(0, 32'h0001_0000, 32'h0002_0000);
    push_coef(0, '0, '0);
    push_coef(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    push_coef(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    push_coef(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    push_coef(32'hffff_0000, 32'h0000_0000, 32'h0001_0000);
    push_coef(32'h0001_0000, 32'h0000_0000, 32'hffff_0000);
    push_coef(32'h0002_0000, 32'hfffd_0000, 32'h0001_0000);
    push_coef(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000);
    push_coef(32'h0000_0001, 32'h8000_0000, 32'h0000_0000);
    push_coef(32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff);
    push_coef(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_coef(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_coef(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    push_coef(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    push_coef(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_coef(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
    push_coef(32'hffff_ffff, 32'h0000_0002, 32'hffff_ffff);
    push_coef(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    push_coef(32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0, 1: push_coef($urandom, $urandom, $urandom);
        2: push_coef(pick_extreme(), pick_extreme(), pick_extreme());
        3: begin
          // double root: a = p, b = 2pq, c = pq^2
          p = $signed($urandom_range(0, 255)) - 128;
          q = $signed($urandom_range(0, 63)) - 32;
          push_coef(p, 2 * p * q, p * q * q);
        end
        4: push_coef(0, $urandom, $urandom);
        default: push_coef(pick_scaled(), pick_scaled(), pick_scaled());
      endcase
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    wait (n_taken == n_total && roots_queue.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // input side: capture items taken by the block and predict their roots
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    cycles <= cycles + 1;
    if (in_valid && in_ready) begin
      roots_queue.push_back(solve_roots('{in_coef_a, in_coef_b, in_coef_c}));
      n_taken <= n_taken + 1;
    end
  end

  // sender: next item on the falling edge, random gaps before items
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (coef_queue.size() > 0 &&
                   (in_valid || n_sent >= n_total - QUIET_TAIL ||
                    $urandom_range(0, 3) != 0)) begin
        in_coef_a <= coef_queue[0].a;
        in_coef_b <= coef_queue[0].b;
        in_coef_c <= coef_queue[0].c;
        void'(coef_queue.pop_front());
        n_sent <= n_sent + 1;
        in_valid <= 1'b1;
      end else if (coef_queue.size() > 0) begin
        send_gap <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else in_valid <= 1'b0;
    end
  end

  // receiver: random stall bursts plus one long hold-off mid-run
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (!hold_done && n_sent >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 250;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
      recv_gap <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // result check against the oldest predicted item
  always @(posedge clk) begin
    roots_t want;
    if (out_valid && out_ready) begin
      if (roots_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: kind %0d", out_root_kind);
      end else begin
        want = roots_queue.pop_front();
        if (out_root_kind !== want.kind || out_first_value !== want.first ||
            out_second_value !== want.second || out_saturated !== want.sat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind %0d first %h second %h sat %b, got %0d %h %h %b",
                     want.kind, want.first, want.second, want.sat, out_root_kind,
                     out_first_value, out_second_value, out_saturated);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt_cell.sv
rtl/core/qrs_div_cell.sv
rtl/core/quadratic_root_solver.sv
tb/sv/tb_top.sv
